// ===== hw/rtl/tdvs_pkg.sv =====
// Package for the tile dihedral view store: field widths, codes, the
// orientation type and the transform composition function.
// No dependencies; compiled first.
package tdvs_pkg;

   // Default sizes handed to the top level
   localparam int SIDE_MAX_DEF  = 64;
   localparam int CELL_BITS_DEF = 32;

   // Fixed field widths
   localparam int KIND_W    = 2;
   localparam int INDEX_W   = 6;
   localparam int VALUE_W   = 32;
   localparam int OP_W      = 3;
   localparam int TURNS_W   = 2;
   localparam int SIDE_W    = 7;
   localparam int ROT_STEPS = 3;

   // CSR port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_SIDE_IN_USE = CSR_IDX_W'(0);
   localparam logic [SIDE_W-1:0]    SIDE_RESET      = SIDE_W'(2);

   // Transaction kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_XFORM = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   // Transform operations
   typedef enum logic [OP_W-1:0] {
      OP_FLIP_ROWS      = 3'd0,
      OP_FLIP_COLS      = 3'd1,
      OP_TRANSPOSE      = 3'd2,
      OP_ANTI_TRANSPOSE = 3'd3,
      OP_ROTATE         = 3'd4
   } xform_op_type;

   // View orientation in D4: flips, then swap of axes
   typedef struct packed {
      logic swap;
      logic flip_r;
      logic flip_c;
   } orient_type;

   localparam orient_type ORIENT_IDENTITY = '{swap: 1'b0, flip_r: 1'b0, flip_c: 1'b0};

   // Command presented by stage 1 to the view map
   typedef struct packed {
      logic               fire;
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic [OP_W-1:0]    op;
      logic [TURNS_W-1:0] turns;
   } view_cmd_type;

   // Compose one transform into the orientation
   function automatic orient_type apply_xform(orient_type o, logic [OP_W-1:0] op,
                                              logic [TURNS_W-1:0] turns);
      orient_type r;
      r = o;
      case (op)
         OP_FLIP_ROWS:      r.flip_r = !o.flip_r;
         OP_FLIP_COLS:      r.flip_c = !o.flip_c;
         OP_TRANSPOSE:      r = '{swap: !o.swap, flip_r: o.flip_c, flip_c: o.flip_r};
         OP_ANTI_TRANSPOSE: r = '{swap: !o.swap, flip_r: !o.flip_c, flip_c: !o.flip_r};
         OP_ROTATE: begin
            // one clockwise quarter turn = flip rows, then transpose
            for (int i = 0; i < ROT_STEPS; i++) begin
               if (i < int'(turns)) begin
                  r = '{swap: !r.swap, flip_r: r.flip_c, flip_c: !r.flip_r};
               end
            end
         end
         default: r = o;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/tdvs_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on tdvs_pkg for field widths.
interface tdvs_req_if;
   import tdvs_pkg::*;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [INDEX_W-1:0] row_index;
   logic [INDEX_W-1:0] col_index;
   logic [VALUE_W-1:0] cell_value;
   logic [OP_W-1:0]    transform_op;
   logic [TURNS_W-1:0] turns;

   modport source (output valid, kind, row_index, col_index, cell_value, transform_op,
                   turns, input ready);
   modport sink (input valid, kind, row_index, col_index, cell_value, transform_op,
                 turns, output ready);
endinterface

interface tdvs_rsp_if;
   import tdvs_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] read_value;
   logic               index_error;

   modport source (output valid, read_value, index_error, input ready);
   modport sink (input valid, read_value, index_error, output ready);
endinterface

// ===== hw/rtl/tdvs_csr.sv =====
// APB-style configuration register block: holds side_in_use.
// Depends on tdvs_pkg.
module tdvs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tdvs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tdvs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tdvs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [tdvs_pkg::SIDE_W-1:0]       side_in_use
);
   import tdvs_pkg::*;

   logic [SIDE_W-1:0]    side_ff;
   logic [SIDE_W-1:0]    side_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register write
   always_comb begin
      side_in = side_ff;
      if (wr_en && (reg_idx == REG_SIDE_IN_USE)) begin
         side_in = csr_pwdata[SIDE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_RESET;
      end else begin
         side_ff <= side_in;
      end
   end

   // Read back, zero-wait
   assign csr_prdata  = (reg_idx == REG_SIDE_IN_USE) ? CSR_DATA_W'(side_ff) : '0;
   assign csr_pready  = 1'b1;
   assign side_in_use = side_ff;

endmodule

// ===== hw/rtl/tdvs_view_map.sv =====
// Orientation register and view-to-storage address remap.
// Depends on tdvs_pkg.
module tdvs_view_map #(
   parameter  int SIDE_MAX = tdvs_pkg::SIDE_MAX_DEF,
   localparam int ADDR_W   = $clog2(SIDE_MAX * SIDE_MAX)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tdvs_pkg::SIDE_W-1:0]   side_in_use,
   input  tdvs_pkg::view_cmd_type        cmd,
   output logic                          index_error,
   output logic [ADDR_W-1:0]             addr
);
   import tdvs_pkg::*;

   localparam int CW = (SIDE_MAX > 1) ? $clog2(SIDE_MAX) : 1;
   localparam int EW = (CW + 1 > SIDE_W) ? CW + 1 : SIDE_W;

   orient_type    orient_ff;
   orient_type    orient_in;
   logic          xform_fire;
   logic [EW-1:0] side_eff;
   logic [EW-1:0] row_e;
   logic [EW-1:0] col_e;
   logic [EW-1:0] row_f;
   logic [EW-1:0] col_f;
   logic [EW-1:0] phys_r;
   logic [EW-1:0] phys_c;

   // Orientation update on a transform transaction
   assign xform_fire = cmd.fire && (cmd.kind == KIND_XFORM);

   always_comb begin
      orient_in = orient_ff;
      if (xform_fire) begin
         orient_in = apply_xform(orient_ff, cmd.op, cmd.turns);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff <= ORIENT_IDENTITY;
      end else begin
         orient_ff <= orient_in;
      end
   end

   // Clamp side to 1..SIDE_MAX
   always_comb begin
      if (side_in_use == '0) begin
         side_eff = EW'(1);
      end else if (EW'(side_in_use) > EW'(SIDE_MAX)) begin
         side_eff = EW'(SIDE_MAX);
      end else begin
         side_eff = EW'(side_in_use);
      end
   end

   // Bounds check and remap: flips first, then optional axis swap
   assign row_e       = EW'(cmd.row);
   assign col_e       = EW'(cmd.col);
   assign index_error = (row_e >= side_eff) || (col_e >= side_eff);
   assign row_f       = orient_ff.flip_r ? (side_eff - EW'(1) - row_e) : row_e;
   assign col_f       = orient_ff.flip_c ? (side_eff - EW'(1) - col_e) : col_e;
   assign phys_r      = orient_ff.swap ? col_f : row_f;
   assign phys_c      = orient_ff.swap ? row_f : col_f;
   assign addr        = ADDR_W'(phys_r[CW-1:0]) * ADDR_W'(SIDE_MAX) + ADDR_W'(phys_c[CW-1:0]);

   // Orientation only moves on a transform
   a_orient_hold: assert property (@(posedge clock) disable iff (reset)
      !xform_fire |=> $stable(orient_ff))
      else $error("orientation changed without a transform");

endmodule

// ===== hw/rtl/tdvs_cell_mem.sv =====
// Single-port cell store with registered, enabled read data.
// Depends on tdvs_pkg.
module tdvs_cell_mem #(
   parameter int DEPTH  = tdvs_pkg::SIDE_MAX_DEF * tdvs_pkg::SIDE_MAX_DEF,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = tdvs_pkg::CELL_BITS_DEF
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);
   import tdvs_pkg::*;

   logic [DATA_W-1:0] cell_store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write and read; read register holds while not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_store_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cell_store_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tile_dihedral_view_store_core.sv =====
// Channel   | Direction | Handshake          | Payload
// req_ch    | in        | valid/ready        | kind, row/col index, cell value, op, turns
// rsp_ch    | out       | valid/ready        | read_value, index_error
// csr_*     | in/out    | APB psel/penable   | side_in_use at byte address 0
//
// One transaction per cycle while no response stalls. Stage 1 registers the request;
// the view remap and the single-port cell memory access follow; the memory's read
// register forms the response stage, so a result passes stage 1, then the response stage.
// Transforms and unused kinds finish in stage 1 and give no response.
// A stalled response holds stage 2; stage 1 still fills once behind it.
// Synchronous active-high reset clears valids, orientation and side (2); cells are
// undefined until written, and no clearing pass is run.
// Depends on tdvs_pkg, tdvs_if, tdvs_csr, tdvs_view_map, tdvs_cell_mem.
module tile_dihedral_view_store_core #(
   parameter int SIDE_MAX  = tdvs_pkg::SIDE_MAX_DEF,
   parameter int CELL_BITS = tdvs_pkg::CELL_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   tdvs_req_if.sink                          req_ch,
   tdvs_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tdvs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tdvs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tdvs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import tdvs_pkg::*;

   localparam int DEPTH  = SIDE_MAX * SIDE_MAX;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int WIDE_W = (CELL_BITS > VALUE_W) ? CELL_BITS : VALUE_W;

   logic                 s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0]    s1_kind_ff;
   logic [INDEX_W-1:0]   s1_row_ff;
   logic [INDEX_W-1:0]   s1_col_ff;
   logic [VALUE_W-1:0]   s1_value_ff;
   logic [OP_W-1:0]      s1_op_ff;
   logic [TURNS_W-1:0]   s1_turns_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_err_ff, rsp_err_in;
   logic                 rsp_read_ff, rsp_read_in;
   logic                 s1_adv;
   logic                 s1_fire;
   logic                 s1_has_rsp;
   logic                 req_fire;
   logic [SIDE_W-1:0]    side_in_use;
   view_cmd_type         cmd;
   logic                 map_err;
   logic [ADDR_W-1:0]    map_addr;
   logic                 mem_we;
   logic                 mem_re;
   logic [WIDE_W-1:0]    wr_wide;
   logic [WIDE_W-1:0]    rd_wide;
   logic [CELL_BITS-1:0] mem_rdata;

   // Configuration
   tdvs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .side_in_use (side_in_use)
   );

   // Pipeline flow control
   assign s1_adv       = !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && s1_adv;
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign s1_has_rsp   = (s1_kind_ff == KIND_WRITE) || (s1_kind_ff == KIND_READ);

   // Stage 1: request register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ch.ready) begin
         s1_valid_in = req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff  <= req_ch.kind;
         s1_row_ff   <= req_ch.row_index;
         s1_col_ff   <= req_ch.col_index;
         s1_value_ff <= req_ch.cell_value;
         s1_op_ff    <= req_ch.transform_op;
         s1_turns_ff <= req_ch.turns;
      end
   end

   // View remap and orientation
   assign cmd = '{fire: s1_fire, kind: s1_kind_ff, row: s1_row_ff, col: s1_col_ff,
                  op: s1_op_ff, turns: s1_turns_ff};

   tdvs_view_map #(
      .SIDE_MAX (SIDE_MAX)
   ) u_view_map (
      .clock       (clock),
      .reset       (reset),
      .side_in_use (side_in_use),
      .cmd         (cmd),
      .index_error (map_err),
      .addr        (map_addr)
   );

   // Cell memory access
   assign mem_we  = s1_fire && (s1_kind_ff == KIND_WRITE) && !map_err;
   assign mem_re  = s1_fire && (s1_kind_ff == KIND_READ) && !map_err;
   assign wr_wide = WIDE_W'(s1_value_ff);

   tdvs_cell_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (CELL_BITS)
   ) u_cell_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (map_addr),
      .wr_data (wr_wide[CELL_BITS-1:0]),
      .rd_data (mem_rdata)
   );

   // Stage 2: response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_read_in  = rsp_read_ff;
      if (s1_adv) begin
         rsp_valid_in = s1_valid_ff && s1_has_rsp;
         rsp_err_in   = map_err;
         rsp_read_in  = (s1_kind_ff == KIND_READ) && !map_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_err_ff  <= rsp_err_in;
      rsp_read_ff <= rsp_read_in;
   end

   assign rd_wide            = WIDE_W'(mem_rdata);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.index_error = rsp_err_ff;
   assign rsp_ch.read_value  = rsp_read_ff ? rd_wide[VALUE_W-1:0] : '0;

   // Empty stage 1 always takes a transaction
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ch.ready)
      else $error("request stalled with stage 1 empty");

   // A blocked stage 1 keeps its transaction
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_kind_ff) && $stable(s1_row_ff)
                                 && $stable(s1_col_ff))
      else $error("stage 1 lost a stalled transaction");

   // Transforms and no-ops leave no response behind
   a_no_rsp_for_xform: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !s1_has_rsp |=> !rsp_valid_ff)
      else $error("response produced for a transaction without one");

   // Error responses carry zero data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> !rsp_read_ff)
      else $error("error response marked as read data");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for tile_dihedral_view_store_core: directed table, then random
// traffic over several side settings, with responses checked against an internal model.
// Depends on tdvs_pkg, tdvs_if and the core RTL.
module testbench;
   import tdvs_pkg::*;

   localparam int SIDE_MAX     = SIDE_MAX_DEF;
   localparam int CELL_DEPTH   = SIDE_MAX * SIDE_MAX;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_WAIT  = 4;
   localparam int DRAIN_WAIT   = 8;
   localparam int PHASE_ITEMS  = 180;
   localparam int DIR_ROWS     = 26;
   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

   typedef struct packed {
      kind_type            kind;
      logic [INDEX_W-1:0]  row;
      logic [INDEX_W-1:0]  col;
      logic [VALUE_W-1:0]  value;
      logic [OP_W-1:0]     op;
      logic [TURNS_W-1:0]  turns;
   } tile_cmd_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  read_value;
      logic                index_error;
   } tile_rsp_type;

   // directed row: command plus an optional hand-written response
   typedef struct packed {
      kind_type            kind;
      logic [INDEX_W-1:0]  row;
      logic [INDEX_W-1:0]  col;
      logic [VALUE_W-1:0]  value;
      logic [OP_W-1:0]     op;
      logic [TURNS_W-1:0]  turns;
      logic                typed;
      logic [VALUE_W-1:0]  exp_value;
      logic                exp_error;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tdvs_req_if req_if ();
   tdvs_rsp_if rsp_if ();

   tile_dihedral_view_store_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Model state: tile contents, orientation and side register
   logic [VALUE_W-1:0] cell_mem [CELL_DEPTH];
   bit                 cell_written [CELL_DEPTH];
   int                 written_addrs [$];
   bit                 o_swap;
   bit                 o_flip_r;
   bit                 o_flip_c;
   logic [SIDE_W-1:0]  side_reg;

   tile_rsp_type cell_rsp_q [$];
   dir_row_type  dir_table [DIR_ROWS];

   int  errors;
   int  cycle_count;
   int  rsp_checked;
   int  n_writes, n_reads, n_xforms, n_nops, n_sides;
   bit  quiet_mode;
   int  ready_hold;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response backpressure: alternating ready/stall bursts
   always @(negedge clock) begin
      if (quiet_mode) begin
         rsp_if.ready = 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold--;
      end else if (rsp_if.ready) begin
         rsp_if.ready = 1'b0;
         ready_hold = $urandom_range(1, 12) - 1;
      end else begin
         rsp_if.ready = 1'b1;
         ready_hold = $urandom_range(1, 30) - 1;
      end
   end

   // Response checker
   always @(posedge clock) begin : rsp_check
      tile_rsp_type exp_rsp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (cell_rsp_q.size() == 0) begin
            $error("unexpected response: read_value %h index_error %b",
                   rsp_if.read_value, rsp_if.index_error);
            errors++;
         end else begin
            exp_rsp = cell_rsp_q.pop_front();
            rsp_checked++;
            if (rsp_if.read_value !== exp_rsp.read_value) begin
               $error("read_value mismatch: expected %h, actual %h",
                      exp_rsp.read_value, rsp_if.read_value);
               errors++;
            end
            if (rsp_if.index_error !== exp_rsp.index_error) begin
               $error("index_error mismatch: expected %b, actual %b",
                      exp_rsp.index_error, rsp_if.index_error);
               errors++;
            end
         end
      end
   end

   // Side actually used: 0 acts as 1, anything above SIDE_MAX as SIDE_MAX
   function automatic int effective_side();
      int s;
      s = int'(side_reg);
      if (s < 1) s = 1;
      if (s > SIDE_MAX) s = SIDE_MAX;
      return s;
   endfunction

   // View position to stored address under the current orientation
   function automatic int stored_addr(int r, int c, int s);
      int a;
      int b;
      a = o_flip_r ? (s - 1 - r) : r;
      b = o_flip_c ? (s - 1 - c) : c;
      return o_swap ? (b * SIDE_MAX + a) : (a * SIDE_MAX + b);
   endfunction

   task automatic transpose_view();
      bit t;
      t = o_flip_r;
      o_flip_r = o_flip_c;
      o_flip_c = t;
      o_swap = !o_swap;
   endtask

   // Apply one accepted transaction to the model and produce its response
   task automatic predict_view_access(input tile_cmd_type cmd, output bit has_rsp,
                                      output tile_rsp_type rsp);
      int  s;
      int  addr;
      bit  err;
      bit  t;
      s = effective_side();
      err = (int'(cmd.row) >= s) || (int'(cmd.col) >= s);
      has_rsp = 1'b0;
      rsp = '0;
      case (cmd.kind)
         KIND_XFORM: begin
            case (cmd.op)
               OP_FLIP_ROWS: o_flip_r = !o_flip_r;
               OP_FLIP_COLS: o_flip_c = !o_flip_c;
               OP_TRANSPOSE: transpose_view();
               OP_ANTI_TRANSPOSE: begin
                  t = o_flip_r;
                  o_flip_r = !o_flip_c;
                  o_flip_c = !t;
                  o_swap = !o_swap;
               end
               OP_ROTATE: begin
                  // clockwise quarter turn: flip rows, then transpose
                  for (int i = 0; i < int'(cmd.turns); i++) begin
                     o_flip_r = !o_flip_r;
                     transpose_view();
                  end
               end
               default: ;
            endcase
         end
         KIND_WRITE, KIND_READ: begin
            has_rsp = 1'b1;
            rsp.index_error = err;
            if (!err) begin
               addr = stored_addr(cmd.row, cmd.col, s);
               if (cmd.kind == KIND_WRITE) begin
                  cell_mem[addr] = cmd.value;
                  if (!cell_written[addr]) begin
                     cell_written[addr] = 1'b1;
                     written_addrs.push_back(addr);
                  end
               end else begin
                  rsp.read_value = cell_mem[addr];
               end
            end
         end
         default: ;
      endcase
   endtask

   // Random transaction; reads in range only touch cells already written
   function automatic tile_cmd_type random_cmd();
      tile_cmd_type cmd;
      int  s;
      int  pick;
      int  addr;
      int  a;
      int  b;
      bit  found;
      s = effective_side();
      cmd.row   = INDEX_W'($urandom_range(0, 63));
      cmd.col   = INDEX_W'($urandom_range(0, 63));
      cmd.value = $urandom;
      cmd.op    = OP_W'($urandom_range(0, 7));
      cmd.turns = TURNS_W'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 38) cmd.kind = KIND_WRITE;
      else if (pick < 76) cmd.kind = KIND_READ;
      else if (pick < 94) cmd.kind = KIND_XFORM;
      else cmd.kind = KIND_NOP;
      if (cmd.kind == KIND_XFORM && $urandom_range(0, 9) != 0)
         cmd.op = OP_W'($urandom_range(int'(OP_FLIP_ROWS), int'(OP_ROTATE)));
      if (cmd.kind == KIND_WRITE || cmd.kind == KIND_READ) begin
         if (s < SIDE_MAX && $urandom_range(0, 6) == 0) begin
            // bad index on one axis, the other left random
            if ($urandom_range(0, 1)) cmd.row = INDEX_W'($urandom_range(s, 63));
            else cmd.col = INDEX_W'($urandom_range(s, 63));
         end else begin
            cmd.row = INDEX_W'($urandom_range(0, s - 1));
            cmd.col = INDEX_W'($urandom_range(0, s - 1));
            if (cmd.kind == KIND_READ && !cell_written[stored_addr(cmd.row, cmd.col, s)]) begin
               found = 1'b0;
               for (int k = 0; k < 8 && !found && written_addrs.size() != 0; k++) begin
                  addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
                  if (addr / SIDE_MAX < s && addr % SIDE_MAX < s) begin
                     // invert the view mapping
                     a = o_swap ? addr % SIDE_MAX : addr / SIDE_MAX;
                     b = o_swap ? addr / SIDE_MAX : addr % SIDE_MAX;
                     cmd.row = INDEX_W'(o_flip_r ? (s - 1 - a) : a);
                     cmd.col = INDEX_W'(o_flip_c ? (s - 1 - b) : b);
                     found = 1'b1;
                  end
               end
               if (!found) cmd.kind = KIND_WRITE;
            end
         end
      end
      return cmd;
   endfunction

   // Drive one request transaction, with an optional idle burst ahead of it
   task automatic send_cmd(input tile_cmd_type cmd, input bit typed,
                           input tile_rsp_type typed_rsp);
      bit           has_rsp;
      tile_rsp_type rsp;
      @(negedge clock);
      if (!quiet_mode && $urandom_range(0, 3) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_if.kind         = cmd.kind;
      req_if.row_index    = cmd.row;
      req_if.col_index    = cmd.col;
      req_if.cell_value   = cmd.value;
      req_if.transform_op = cmd.op;
      req_if.turns        = cmd.turns;
      req_if.valid        = 1'b1;
      forever begin
         @(posedge clock);
         if (req_if.ready) break;
      end
      predict_view_access(cmd, has_rsp, rsp);
      if (has_rsp) cell_rsp_q.push_back(typed ? typed_rsp : rsp);
      case (cmd.kind)
         KIND_WRITE: n_writes++;
         KIND_READ:  n_reads++;
         KIND_XFORM: n_xforms++;
         default:    n_nops++;
      endcase
   endtask

   // Wait for all responses, then let the pipeline settle
   task automatic wait_idle(input int settle);
      @(negedge clock);
      req_if.valid = 1'b0;
      while (cell_rsp_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // APB write of side_in_use, then read it back
   task automatic write_side(input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {REG_SIDE_IN_USE, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready) break;
      end
      side_reg = data[SIDE_W-1:0];
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready) break;
      end
      if (csr_prdata !== CSR_DATA_W'(data[SIDE_W-1:0])) begin
         $error("side_in_use readback mismatch: expected %h, actual %h",
                CSR_DATA_W'(data[SIDE_W-1:0]), csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      n_sides++;
   endtask

   initial begin : stimulus
      tile_cmd_type cmd;
      tile_rsp_type rsp;
      int           side_plan [11];
      logic [CSR_DATA_W-1:0] data;

      // quiet inputs from time zero
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.kind         = KIND_NOP;
      req_if.row_index    = '0;
      req_if.col_index    = '0;
      req_if.cell_value   = '0;
      req_if.transform_op = OP_FLIP_ROWS;
      req_if.turns        = '0;
      rsp_if.ready        = 1'b1;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      quiet_mode          = 1'b0;
      ready_hold          = 0;
      o_swap              = 1'b0;
      o_flip_r            = 1'b0;
      o_flip_c            = 1'b0;
      side_reg            = SIDE_RESET;

      // side 2 after reset, identity orientation
      dir_table = '{
         '{KIND_WRITE, 0,  0,  32'h0000_0000, OP_FLIP_ROWS,      0, 1, 32'h0, 0},
         '{KIND_WRITE, 0,  1,  32'hFFFF_FFFF, OP_FLIP_ROWS,      0, 1, 32'h0, 0},
         '{KIND_WRITE, 1,  0,  32'hA5A5_A5A5, OP_FLIP_ROWS,      0, 1, 32'h0, 0},
         '{KIND_WRITE, 1,  1,  32'h5A5A_5A5A, OP_FLIP_ROWS,      0, 1, 32'h0, 0},
         '{KIND_WRITE, 2,  0,  32'hDEAD_BEEF, OP_FLIP_ROWS,      0, 1, 32'h0, 1},
         '{KIND_WRITE, 0,  63, 32'h1234_5678, OP_FLIP_ROWS,      0, 1, 32'h0, 1},
         '{KIND_READ,  63, 63, 32'hFFFF_FFFF, OP_FLIP_ROWS,      3, 1, 32'h0, 1},
         '{KIND_XFORM, 0,  0,  32'h0,         OP_FLIP_ROWS,      0, 0, 32'h0, 0},
         '{KIND_READ,  0,  0,  32'h0,         OP_FLIP_ROWS,      0, 0, 32'h0, 0},
         '{KIND_XFORM, 0,  0,  32'h0,         OP_FLIP_COLS,      0, 0, 32'h0, 0},
         '{KIND_READ,  0,  1,  32'h0,         OP_FLIP_ROWS,      0, 0, 32'h0, 0},
         '{KIND_XFORM, 0,  0,  32'h0,         OP_TRANSPOSE,      0, 0, 32'h0, 0},
         '{KIND_READ,  1,  0,  32'h0,         OP_FLIP_ROWS,      0, 0, 32'h0, 0},
         '{KIND_XFORM, 0,  0,  32'h0,         OP_ANTI_TRANSPOSE, 0, 0, 32'h0, 0},
         '{KIND_READ,  1,  0,  32'h0,         OP_FLIP_ROWS,      0, 0, 32'h0, 0},
         '{KIND_XFORM, 0,  0,  32'h0,         OP_ROTATE,         0, 0, 32'h0, 0},
         '{KIND_XFORM, 0,  0,  32'h0,         OP_ROTATE,         1, 0, 32'h0, 0},
         '{KIND_READ,  0,  1,  32'h0,         OP_FLIP_ROWS,      0, 0, 32'h0, 0},
         '{KIND_XFORM, 0,  0,  32'h0,         OP_ROTATE,         2, 0, 32'h0, 0},
         '{KIND_READ,  1,  1,  32'h0,         OP_FLIP_ROWS,      0, 0, 32'h0, 0},
         '{KIND_XFORM, 0,  0,  32'h0,         OP_ROTATE,         3, 0, 32'h0, 0},
         '{KIND_READ,  1,  0,  32'h0,         OP_FLIP_ROWS,      0, 0, 32'h0, 0},
         '{KIND_XFORM, 0,  0,  32'h0,         OP_UNUSED_LO,      3, 0, 32'h0, 0},
         '{KIND_XFORM, 0,  0,  32'h0,         OP_UNUSED_HI,      0, 0, 32'h0, 0},
         '{KIND_NOP,   63, 63, 32'hFFFF_FFFF, OP_UNUSED_HI,      3, 0, 32'h0, 0},
         '{KIND_READ,  0,  0,  32'h0,         OP_FLIP_ROWS,      0, 0, 32'h0, 0}
      };

      // extremes first, out-of-range sides, then mixed; last phase runs without idling
      side_plan = '{SIDE_MAX, 1, 0, 127, 5, SIDE_MAX + 1, 3,
                    $urandom_range(1, SIDE_MAX), $urandom_range(1, SIDE_MAX), 2, 8};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      for (int i = 0; i < DIR_ROWS; i++) begin
         cmd = '{dir_table[i].kind, dir_table[i].row, dir_table[i].col,
                 dir_table[i].value, dir_table[i].op, dir_table[i].turns};
         rsp = '{dir_table[i].exp_value, dir_table[i].exp_error};
         send_cmd(cmd, dir_table[i].typed, rsp);
      end

      // random phases, one side setting each
      for (int p = 0; p < $size(side_plan); p++) begin
         wait_idle(SETTLE_WAIT);
         data = CSR_DATA_W'(side_plan[p]);
         if (p % 2 == 1) data = ($urandom & 32'hFFFF_FF80) | data;
         write_side(data);
         if (p == $size(side_plan) - 1) quiet_mode = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) send_cmd(random_cmd(), 1'b0, '0);
      end

      wait_idle(DRAIN_WAIT);
      while (cell_rsp_q.size() != 0) begin
         rsp = cell_rsp_q.pop_front();
         $error("missing response: expected read_value %h index_error %b",
                rsp.read_value, rsp.index_error);
         errors++;
      end

      $display("Coverage: %0d writes, %0d reads, %0d transforms, %0d no-ops over %0d sides",
               n_writes, n_reads, n_xforms, n_nops, n_sides);
      $display("Responses checked: %0d, cells touched: %0d, errors: %0d",
               rsp_checked, written_addrs.size(), errors);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== tile_dihedral_view_store_core.f =====
hw/rtl/tdvs_pkg.sv
hw/rtl/tdvs_if.sv
hw/rtl/tdvs_csr.sv
hw/rtl/tdvs_view_map.sv
hw/rtl/tdvs_cell_mem.sv
hw/rtl/tile_dihedral_view_store_core.sv
bench/testbench.sv
